>>> design/swlr_pkg.sv
// Shared constants, codes, handshake structs and saturation helper for the line-fit block.
package swlr_pkg;

	localparam int DATA_W = 32;
	localparam int FIX_W = 48;
	localparam int WIDE_W = 128;
	localparam int FRAC = 16;
	localparam int MUL_STEPS = 48;
	localparam int MUL_BW = MUL_STEPS + 1;
	localparam int WS_W = 7;
	localparam int WS_RESET = 64;
	localparam int DEF_WINDOW_DEPTH = 64;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_FIT = 2'd1;
	localparam logic [1:0] REQ_PREDICT = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP = 5'd0;
	localparam logic [OP_W-1:0] OP_LATCH = 5'd1;
	localparam logic [OP_W-1:0] OP_ADD = 5'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 5'd3;
	localparam logic [OP_W-1:0] OP_FINIT = 5'd4;
	localparam logic [OP_W-1:0] OP_RD = 5'd5;
	localparam logic [OP_W-1:0] OP_XY = 5'd6;
	localparam logic [OP_W-1:0] OP_XX = 5'd7;
	localparam logic [OP_W-1:0] OP_ACC = 5'd8;
	localparam logic [OP_W-1:0] OP_M_DEN1 = 5'd9;
	localparam logic [OP_W-1:0] OP_C_DEN1 = 5'd10;
	localparam logic [OP_W-1:0] OP_M_DEN2 = 5'd11;
	localparam logic [OP_W-1:0] OP_C_DEN2 = 5'd12;
	localparam logic [OP_W-1:0] OP_M_NUM1 = 5'd13;
	localparam logic [OP_W-1:0] OP_C_NUM1 = 5'd14;
	localparam logic [OP_W-1:0] OP_M_NUM2 = 5'd15;
	localparam logic [OP_W-1:0] OP_C_NUM2 = 5'd16;
	localparam logic [OP_W-1:0] OP_D_SLOPE = 5'd17;
	localparam logic [OP_W-1:0] OP_C_SLOPE = 5'd18;
	localparam logic [OP_W-1:0] OP_M_T = 5'd19;
	localparam logic [OP_W-1:0] OP_C_T = 5'd20;
	localparam logic [OP_W-1:0] OP_D_ICPT = 5'd21;
	localparam logic [OP_W-1:0] OP_C_ICPT = 5'd22;
	localparam logic [OP_W-1:0] OP_M_PRED = 5'd23;
	localparam logic [OP_W-1:0] OP_C_PRED1 = 5'd24;
	localparam logic [OP_W-1:0] OP_PRED2 = 5'd25;
	localparam logic [OP_W-1:0] OP_RESULT = 5'd26;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic few;
		logic walk_done;
		logic den_zero;
		logic mul_done;
		logic div_done;
		logic out_free;
	} stat_t;

	localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
	localparam logic signed [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

	// Saturate a wide two's-complement value to the 48-bit result format.
	function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-FIX_W:0] top;
		top = v[WIDE_W-1:FIX_W-1];
		if (top == '0 || top == '1) return v[FIX_W-1:0];
		else if (v[WIDE_W-1]) return FIX_MIN;
		else return FIX_MAX;
	endfunction

endpackage

>>> design/swlr_ifs.sv
// Request and result channel interfaces of the line-fit block.
interface swlr_req_if;
	import swlr_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic signed [DATA_W-1:0] x_value;
	logic signed [DATA_W-1:0] y_value;
	modport source (output valid, output req_type, output x_value, output y_value, input ready);
	modport sink (input valid, input req_type, input x_value, input y_value, output ready);
endinterface

interface swlr_res_if;
	import swlr_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [FIX_W-1:0] slope;
	logic signed [FIX_W-1:0] intercept;
	logic signed [FIX_W-1:0] prediction;
	modport source (output valid, output status, output slope, output intercept,
		output prediction, input ready);
	modport sink (input valid, input status, input slope, input intercept,
		input prediction, output ready);
endinterface

>>> design/sliding_window_linear_regression.sv
// Top level of the sliding-window least-squares line fit block.
//
//  channel  | dir | payload                                   | transfer
//  req      | in  | req_type, x_value, y_value                | valid && ready
//  res      | out | status, slope, intercept, prediction      | valid && ready
//  cfg      | in  | cfg_wdata (window size)                   | cfg_we
//
// One request is in work at a time; the next is taken once the result sits in the
// output register, which holds it until the sink takes the transaction.
// Predict runs one 48-step shift-add multiply.
// Fit walks the n stored points to form the sums, then runs five 48-step multiplies
// and two 128-step divides, unless too few points or a zero denominator end it early.
// Reset (arst_n low) empties the window, zeroes the fit and sets the window size to 64.
module sliding_window_linear_regression #(
	parameter int WINDOW_DEPTH = swlr_pkg::DEF_WINDOW_DEPTH
) (
	input logic clk,
	input logic arst_n,
	swlr_req_if.sink req,
	swlr_res_if.source res,
	input logic cfg_we,
	input logic [swlr_pkg::WS_W-1:0] cfg_wdata
);
	import swlr_pkg::*;

	cmd_t cmd;
	stat_t stat;

	swlr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.cmd(cmd), .stat(stat)
	);

	swlr_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req.req_type), .x_value(req.x_value), .y_value(req.y_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.res_valid(res.valid), .res_ready(res.ready), .status(res.status),
		.slope(res.slope), .intercept(res.intercept), .prediction(res.prediction)
	);
endmodule

>>> design/swlr_mul.sv
// Shift-add multiplier: wide signed operand times a signed operand of up to 48 magnitude bits.
module swlr_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [swlr_pkg::WIDE_W-1:0] a,
	input logic signed [swlr_pkg::MUL_BW-1:0] b,
	output logic signed [swlr_pkg::WIDE_W-1:0] res,
	output logic done
);
	import swlr_pkg::*;

	localparam int STEP_W = $clog2(MUL_STEPS);

	logic run_q, fin_q, done_q, neg_q;
	logic [STEP_W-1:0] step_q;
	logic [WIDE_W-1:0] ma_q, acc_q;
	logic [MUL_STEPS-1:0] mb_q;
	logic signed [WIDE_W-1:0] res_q;
	logic [MUL_BW-1:0] b_abs;

	assign b_abs = b[MUL_BW-1] ? -b : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= run_q && (step_q == STEP_W'(MUL_STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(MUL_STEPS - 1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[WIDE_W-1] ? -a : a;
			mb_q <= b_abs[MUL_STEPS-1:0];
			neg_q <= a[WIDE_W-1] ^ b[MUL_BW-1];
			acc_q <= '0;
		end else if (run_q) begin
			if (mb_q[0]) acc_q <= acc_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		if (fin_q) res_q <= neg_q ? -acc_q : acc_q;
	end

	assign res = res_q;
	assign done = done_q;
endmodule

>>> design/swlr_div.sv
// Restoring divider, one quotient bit a cycle, truncating signed division of wide values.
module swlr_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [swlr_pkg::WIDE_W-1:0] num,
	input logic signed [swlr_pkg::WIDE_W-1:0] den,
	output logic signed [swlr_pkg::WIDE_W-1:0] res,
	output logic done
);
	import swlr_pkg::*;

	localparam int STEP_W = $clog2(WIDE_W);

	logic run_q, fin_q, done_q, neg_q;
	logic [STEP_W-1:0] step_q;
	logic [WIDE_W-1:0] r_q, q_q, d_q, r_sh;
	logic ge;
	logic signed [WIDE_W-1:0] res_q;

	assign r_sh = {r_q[WIDE_W-2:0], q_q[WIDE_W-1]};
	assign ge = (r_sh >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= run_q && (step_q == STEP_W'(WIDE_W - 1));
			if (start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(WIDE_W - 1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[WIDE_W-1] ? -num : num;
			d_q <= den[WIDE_W-1] ? -den : den;
			neg_q <= num[WIDE_W-1] ^ den[WIDE_W-1];
			r_q <= '0;
		end else if (run_q) begin
			r_q <= ge ? r_sh - d_q : r_sh;
			q_q <= {q_q[WIDE_W-2:0], ge};
		end
		if (fin_q) res_q <= neg_q ? -q_q : q_q;
	end

	assign res = res_q;
	assign done = done_q;
endmodule

>>> design/swlr_dp.sv
// Datapath: point stores, sums, fit registers, arithmetic units and the result register.
module swlr_dp #(
	parameter int WINDOW_DEPTH = swlr_pkg::DEF_WINDOW_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input swlr_pkg::cmd_t cmd,
	output swlr_pkg::stat_t stat,
	input logic [1:0] req_type,
	input logic signed [swlr_pkg::DATA_W-1:0] x_value,
	input logic signed [swlr_pkg::DATA_W-1:0] y_value,
	input logic cfg_we,
	input logic [swlr_pkg::WS_W-1:0] cfg_wdata,
	output logic res_valid,
	input logic res_ready,
	output logic [1:0] status,
	output logic signed [swlr_pkg::FIX_W-1:0] slope,
	output logic signed [swlr_pkg::FIX_W-1:0] intercept,
	output logic signed [swlr_pkg::FIX_W-1:0] prediction
);
	import swlr_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = DATA_W + CW;
	localparam int PW = 2 * DATA_W + CW;
	localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
	localparam logic signed [WIDE_W-1:0] RND_BIAS = WIDE_W'((2 ** FRAC) - 1);

	logic [DATA_W-1:0] x_mem [WINDOW_DEPTH];
	logic [DATA_W-1:0] y_mem [WINDOW_DEPTH];
	logic signed [DATA_W-1:0] x_rd_q, y_rd_q, x_q, y_q;
	logic [1:0] req_q;
	logic [WS_W-1:0] ws_q;
	logic [AW-1:0] wr_pos_q, rd_pos_q, start_pos;
	logic [CW-1:0] cnt_q, k_q;
	logic signed [SW-1:0] sx_q, sy_q;
	logic signed [PW-1:0] sxy_q, sxx_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic signed [WIDE_W-1:0] den_q, num_q, t_q, pred_bias;
	logic signed [FIX_W-1:0] slope_q, icpt_q, pred_q;
	logic res_valid_q;
	logic [1:0] res_status_q;
	logic signed [FIX_W-1:0] res_slope_q, res_icpt_q, res_pred_q;
	logic [CW:0] wr_ext, base;

	logic mul_start, div_start, mul_done, div_done;
	logic signed [WIDE_W-1:0] mul_a, mul_res, div_num, div_den, div_res;
	logic signed [MUL_BW-1:0] mul_b;

	function automatic logic [CW-1:0] eff_win(input logic [WS_W-1:0] w);
		if (w == '0) return CW'(1);
		else if (int'(w) > WINDOW_DEPTH) return DEPTH_C;
		else return CW'(w);
	endfunction

	// The oldest stored point sits count entries behind the write position.
	always_comb begin
		wr_ext = (CW+1)'(wr_pos_q);
		base = (wr_ext >= (CW+1)'(cnt_q)) ? wr_ext : wr_ext + (CW+1)'(WINDOW_DEPTH);
		start_pos = AW'(base - (CW+1)'(cnt_q));
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_M_DEN1: begin mul_a = WIDE_W'(sxx_q); mul_b = MUL_BW'(cnt_q); end
			OP_M_DEN2: begin mul_a = WIDE_W'(sx_q); mul_b = MUL_BW'(sx_q); end
			OP_M_NUM1: begin mul_a = WIDE_W'(sxy_q); mul_b = MUL_BW'(cnt_q); end
			OP_M_NUM2: begin mul_a = WIDE_W'(sy_q); mul_b = MUL_BW'(sx_q); end
			OP_M_T: begin mul_a = WIDE_W'(slope_q); mul_b = MUL_BW'(sx_q); end
			OP_M_PRED: begin mul_a = WIDE_W'(slope_q); mul_b = MUL_BW'(x_q); end
			default: mul_start = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b1;
		div_num = '0;
		div_den = '0;
		unique case (cmd.op)
			OP_D_SLOPE: begin div_num = num_q <<< FRAC; div_den = den_q; end
			OP_D_ICPT: begin div_num = t_q; div_den = signed'(WIDE_W'(cnt_q) << FRAC); end
			default: div_start = 1'b0;
		endcase
	end

	// Shifting a negative product right rounds toward zero after this bias.
	assign pred_bias = mul_res[WIDE_W-1] ? RND_BIAS : '0;

	swlr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.res(mul_res), .done(mul_done)
	);

	swlr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.res(div_res), .done(div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ADD) begin
			x_mem[wr_pos_q] <= x_q;
			y_mem[wr_pos_q] <= y_q;
		end
		if (cmd.op == OP_RD) begin
			x_rd_q <= x_mem[rd_pos_q];
			y_rd_q <= y_mem[rd_pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_W'(WS_RESET);
			wr_pos_q <= '0;
			cnt_q <= '0;
			slope_q <= '0;
			icpt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
				if (cnt_q > eff_win(cfg_wdata)) cnt_q <= eff_win(cfg_wdata);
			end
			// A new result may load in the same cycle the previous one is taken.
			if (cmd.op == OP_RESULT) res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_ADD: begin
					wr_pos_q <= (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + 1'b1;
					if (cnt_q < eff_win(ws_q)) cnt_q <= cnt_q + 1'b1;
				end
				OP_CLEAR: begin
					wr_pos_q <= '0;
					cnt_q <= '0;
					slope_q <= '0;
					icpt_q <= '0;
				end
				OP_C_SLOPE: slope_q <= sat_fix(div_res);
				OP_C_ICPT: icpt_q <= sat_fix(div_res);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				req_q <= req_type;
				x_q <= x_value;
				y_q <= y_value;
			end
			OP_FINIT: begin
				rd_pos_q <= start_pos;
				k_q <= '0;
				sx_q <= '0;
				sy_q <= '0;
				sxy_q <= '0;
				sxx_q <= '0;
			end
			OP_RD: begin
				rd_pos_q <= (rd_pos_q == LAST_POS) ? '0 : rd_pos_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			OP_XY: prod_q <= x_rd_q * y_rd_q;
			OP_XX: begin
				sxy_q <= sxy_q + PW'(prod_q);
				prod_q <= x_rd_q * x_rd_q;
				sx_q <= sx_q + SW'(x_rd_q);
				sy_q <= sy_q + SW'(y_rd_q);
			end
			OP_ACC: sxx_q <= sxx_q + PW'(prod_q);
			OP_C_DEN1: den_q <= mul_res;
			OP_C_DEN2: den_q <= den_q - mul_res;
			OP_C_NUM1: num_q <= mul_res;
			OP_C_NUM2: num_q <= num_q - mul_res;
			OP_C_T: t_q <= (WIDE_W'(sy_q) <<< FRAC) - mul_res;
			OP_C_PRED1: t_q <= (mul_res + pred_bias) >>> FRAC;
			OP_PRED2: pred_q <= sat_fix(t_q + WIDE_W'(icpt_q));
			OP_RESULT: begin
				res_status_q <= cmd.res_status;
				res_slope_q <= slope_q;
				res_icpt_q <= icpt_q;
				res_pred_q <= (req_q == REQ_PREDICT) ? pred_q : '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.req = req_q;
		stat.few = (cnt_q < CW'(2));
		stat.walk_done = (k_q == cnt_q);
		stat.den_zero = (den_q == '0);
		stat.mul_done = mul_done;
		stat.div_done = div_done;
		stat.out_free = !res_valid_q || res_ready;
	end

	assign res_valid = res_valid_q;
	assign status = res_status_q;
	assign slope = res_slope_q;
	assign intercept = res_icpt_q;
	assign prediction = res_pred_q;
endmodule

>>> design/swlr_ctrl.sv
// Controller state machine that sequences datapath operations for each request.
module swlr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output swlr_pkg::cmd_t cmd,
	input swlr_pkg::stat_t stat
);
	import swlr_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_ADD = 5'd2;
	localparam logic [4:0] S_CLR = 5'd3;
	localparam logic [4:0] S_FINIT = 5'd4;
	localparam logic [4:0] S_RD = 5'd5;
	localparam logic [4:0] S_XY = 5'd6;
	localparam logic [4:0] S_XX = 5'd7;
	localparam logic [4:0] S_ACC = 5'd8;
	localparam logic [4:0] S_DEN1 = 5'd9;
	localparam logic [4:0] S_DEN1W = 5'd10;
	localparam logic [4:0] S_DEN2 = 5'd11;
	localparam logic [4:0] S_DEN2W = 5'd12;
	localparam logic [4:0] S_CHK = 5'd13;
	localparam logic [4:0] S_NUM1 = 5'd14;
	localparam logic [4:0] S_NUM1W = 5'd15;
	localparam logic [4:0] S_NUM2 = 5'd16;
	localparam logic [4:0] S_NUM2W = 5'd17;
	localparam logic [4:0] S_SLP = 5'd18;
	localparam logic [4:0] S_SLPW = 5'd19;
	localparam logic [4:0] S_T = 5'd20;
	localparam logic [4:0] S_TW = 5'd21;
	localparam logic [4:0] S_ICP = 5'd22;
	localparam logic [4:0] S_ICPW = 5'd23;
	localparam logic [4:0] S_PRED = 5'd24;
	localparam logic [4:0] S_PREDW = 5'd25;
	localparam logic [4:0] S_PRED2 = 5'd26;
	localparam logic [4:0] S_DONE = 5'd27;

	logic [4:0] state_q, state_d;
	logic [1:0] status_q, status_d;

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		in_ready = 1'b0;
		cmd.op = OP_NOP;
		cmd.res_status = status_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LATCH;
					status_d = ST_OK;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.req)
					REQ_ADD: state_d = S_ADD;
					REQ_FIT: begin
						if (stat.few) begin
							status_d = ST_FEW;
							state_d = S_DONE;
						end else begin
							state_d = S_FINIT;
						end
					end
					REQ_PREDICT: state_d = S_PRED;
					default: state_d = S_CLR;
				endcase
			end
			S_ADD: begin cmd.op = OP_ADD; state_d = S_DONE; end
			S_CLR: begin cmd.op = OP_CLEAR; state_d = S_DONE; end
			S_FINIT: begin cmd.op = OP_FINIT; state_d = S_RD; end
			S_RD: begin cmd.op = OP_RD; state_d = S_XY; end
			S_XY: begin cmd.op = OP_XY; state_d = S_XX; end
			S_XX: begin cmd.op = OP_XX; state_d = S_ACC; end
			S_ACC: begin
				cmd.op = OP_ACC;
				state_d = stat.walk_done ? S_DEN1 : S_RD;
			end
			S_DEN1: begin cmd.op = OP_M_DEN1; state_d = S_DEN1W; end
			S_DEN1W: if (stat.mul_done) begin cmd.op = OP_C_DEN1; state_d = S_DEN2; end
			S_DEN2: begin cmd.op = OP_M_DEN2; state_d = S_DEN2W; end
			S_DEN2W: if (stat.mul_done) begin cmd.op = OP_C_DEN2; state_d = S_CHK; end
			S_CHK: begin
				if (stat.den_zero) begin
					status_d = ST_ZERO;
					state_d = S_DONE;
				end else begin
					state_d = S_NUM1;
				end
			end
			S_NUM1: begin cmd.op = OP_M_NUM1; state_d = S_NUM1W; end
			S_NUM1W: if (stat.mul_done) begin cmd.op = OP_C_NUM1; state_d = S_NUM2; end
			S_NUM2: begin cmd.op = OP_M_NUM2; state_d = S_NUM2W; end
			S_NUM2W: if (stat.mul_done) begin cmd.op = OP_C_NUM2; state_d = S_SLP; end
			S_SLP: begin cmd.op = OP_D_SLOPE; state_d = S_SLPW; end
			S_SLPW: if (stat.div_done) begin cmd.op = OP_C_SLOPE; state_d = S_T; end
			S_T: begin cmd.op = OP_M_T; state_d = S_TW; end
			S_TW: if (stat.mul_done) begin cmd.op = OP_C_T; state_d = S_ICP; end
			S_ICP: begin cmd.op = OP_D_ICPT; state_d = S_ICPW; end
			S_ICPW: if (stat.div_done) begin cmd.op = OP_C_ICPT; state_d = S_DONE; end
			S_PRED: begin cmd.op = OP_M_PRED; state_d = S_PREDW; end
			S_PREDW: if (stat.mul_done) begin cmd.op = OP_C_PRED1; state_d = S_PRED2; end
			S_PRED2: begin cmd.op = OP_PRED2; state_d = S_DONE; end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
		end
	end
endmodule

>>> tb/sv/swlr_tb_pkg.sv
// Testbench types used by the line-fit checker.
package swlr_tb_pkg;
	import swlr_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic signed [FIX_W-1:0] slope;
		logic signed [FIX_W-1:0] intercept;
		logic signed [FIX_W-1:0] prediction;
	} fit_result_t;

endpackage

>>> tb/sv/swlr_tb_ifs.sv
// Bundle of configuration signals seen by the line-fit checker.
interface swlr_cfg_mon_if;
	logic we;
	logic [6:0] wdata;
	modport source (output we, output wdata);
	modport sink (input we, input wdata);
endinterface

>>> tb/sv/swlr_checker.sv
// Checker that predicts every line-fit result and compares it with the block output.
module swlr_checker (
	input logic clk,
	input logic arst_n,
	swlr_req_if.sink req,
	swlr_res_if.sink res,
	swlr_cfg_mon_if.sink cfg,
	output int fail_count,
	output int pending_count
);
	import swlr_pkg::*;
	import swlr_tb_pkg::*;

	localparam int DEPTH = DEF_WINDOW_DEPTH;
	localparam int EXP_DEPTH = 16;

	logic signed [DATA_W-1:0] x_mem [DEPTH];
	logic signed [DATA_W-1:0] y_mem [DEPTH];
	int wr_pos;
	int n_points;
	int win_size;
	logic signed [FIX_W-1:0] cur_slope;
	logic signed [FIX_W-1:0] cur_icpt;
	fit_result_t exp_buf [EXP_DEPTH];
	int exp_wr;
	int exp_rd;

	function automatic logic signed [FIX_W-1:0] clamp48(input logic signed [WIDE_W-1:0] v);
		if (v > 128'sh7FFF_FFFF_FFFF) return FIX_MAX;
		if (v < -128'sh8000_0000_0000) return FIX_MIN;
		return v[FIX_W-1:0];
	endfunction

	function automatic int eff_win(input int w);
		if (w < 1) return 1;
		if (w > DEPTH) return DEPTH;
		return w;
	endfunction

	// SystemVerilog signed division already truncates toward zero.
	function automatic logic [1:0] run_fit();
		logic signed [WIDE_W-1:0] sx, sy, sxy, sxx, num, den, t, q, nn;
		logic signed [FIX_W-1:0] s;
		int idx;
		sx = 0; sy = 0; sxy = 0; sxx = 0;
		if (n_points < 2) return ST_FEW;
		idx = (wr_pos + DEPTH - n_points) % DEPTH;
		for (int k = 0; k < n_points; k++) begin
			sx += x_mem[idx];
			sy += y_mem[idx];
			sxy += WIDE_W'(signed'(x_mem[idx])) * WIDE_W'(signed'(y_mem[idx]));
			sxx += WIDE_W'(signed'(x_mem[idx])) * WIDE_W'(signed'(x_mem[idx]));
			idx = (idx + 1) % DEPTH;
		end
		nn = n_points;
		den = nn * sxx - sx * sx;
		if (den == 0) return ST_ZERO;
		num = nn * sxy - sx * sy;
		q = (num <<< FRAC) / den;
		s = clamp48(q);
		t = (sy <<< FRAC) - WIDE_W'(s) * sx;
		cur_slope = s;
		cur_icpt = clamp48(t / (nn <<< FRAC));
		return ST_OK;
	endfunction

	function automatic logic signed [FIX_W-1:0] run_predict(input logic signed [DATA_W-1:0] xv);
		logic signed [WIDE_W-1:0] p;
		p = WIDE_W'(cur_slope) * WIDE_W'(xv);
		p = p / (128'sd1 <<< FRAC);
		return clamp48(p + WIDE_W'(cur_icpt));
	endfunction

	task automatic report_mismatch(input string what, input logic [FIX_W-1:0] got,
		input logic [FIX_W-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fit_result_t r;
		fit_result_t e;
		if (!arst_n) begin
			wr_pos <= 0;
			n_points <= 0;
			win_size <= WS_RESET;
			cur_slope <= '0;
			cur_icpt <= '0;
			fail_count <= 0;
			exp_wr <= 0;
			exp_rd <= 0;
		end else begin
			if (cfg.we) begin
				win_size = cfg.wdata;
				if (n_points > eff_win(win_size)) n_points = eff_win(win_size);
			end
			if (req.valid && req.ready) begin
				r = '0;
				case (req.req_type)
					REQ_ADD: begin
						x_mem[wr_pos] = req.x_value;
						y_mem[wr_pos] = req.y_value;
						wr_pos = (wr_pos + 1) % DEPTH;
						if (n_points < eff_win(win_size)) n_points++;
					end
					REQ_FIT: r.status = run_fit();
					REQ_PREDICT: r.prediction = run_predict(req.x_value);
					default: begin
						n_points = 0;
						wr_pos = 0;
						cur_slope = '0;
						cur_icpt = '0;
					end
				endcase
				r.slope = cur_slope;
				r.intercept = cur_icpt;
				exp_buf[exp_wr % EXP_DEPTH] = r;
				exp_wr = exp_wr + 1;
			end
			if (res.valid && res.ready) begin
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected result", res.slope, '0);
				end else begin
					e = exp_buf[exp_rd % EXP_DEPTH];
					exp_rd = exp_rd + 1;
					if (res.status !== e.status)
						report_mismatch("status", FIX_W'(res.status), FIX_W'(e.status));
					if (res.slope !== e.slope) report_mismatch("slope", res.slope, e.slope);
					if (res.intercept !== e.intercept)
						report_mismatch("intercept", res.intercept, e.intercept);
					if (res.prediction !== e.prediction)
						report_mismatch("prediction", res.prediction, e.prediction);
				end
			end
		end
	end

	assign pending_count = exp_wr - exp_rd;

endmodule

>>> tb/sv/tb_sliding_window_linear_regression.sv
// Stimulus top for the sliding-window line-fit block.
module tb_sliding_window_linear_regression;
	import swlr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [WS_W-1:0] cfg_wdata = '0;
	int fail_count;
	int pending_count;
	int idle_cycles = 0;

	swlr_req_if req_ch ();
	swlr_res_if res_ch ();
	swlr_cfg_mon_if cfg_ch ();

	assign cfg_ch.we = cfg_we;
	assign cfg_ch.wdata = cfg_wdata;

	always #2 clk = ~clk;

	sliding_window_linear_regression i_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .res(res_ch.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	swlr_checker i_checker (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .res(res_ch.sink), .cfg(cfg_ch.sink),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// The sink stalls a random number of cycles before taking each transaction.
	always begin
		int gap;
		@(posedge clk);
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			repeat (gap) @(posedge clk);
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			res_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(input logic [1:0] kind, input logic [31:0] xv,
		input logic [31:0] yv, input bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 17) : 0;
		repeat (gap) @(posedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.x_value <= xv;
		req_ch.y_value <= yv;
		do @(posedge clk); while (!req_ch.ready);
		req_ch.valid <= 1'b0;
	endtask

	task automatic write_window(input logic [WS_W-1:0] value);
		wait (pending_count == 0);
		repeat (600) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] random_coord(input int style);
		case (style)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
			2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	initial begin
		int style;
		int pick;
		logic [31:0] xv;
		logic [31:0] yv;
		logic [WS_W-1:0] sizes [6];
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ADD;
		req_ch.x_value = '0;
		req_ch.y_value = '0;
		sizes = '{7'd2, 7'd0, 7'd127, 7'd64, 7'd1, 7'd9};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: fit on empty and single point, zero denominator, extremes, clear.
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_PREDICT, 32'h7FFF_FFFF, 0, 0);
		send_request(REQ_ADD, 32'h0001_0000, 32'h0002_0000, 0);
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_ADD, 32'h0001_0000, 32'h8000_0000, 0);
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_ADD, 32'h0003_0000, 32'h0006_0000, 0);
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_PREDICT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_request(REQ_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_request(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_PREDICT, 32'h7FFF_FFFF, 0, 0);
		send_request(REQ_PREDICT, 32'h8000_0000, 0, 0);
		send_request(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 0);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 0);
		send_request(REQ_FIT, 0, 0, 0);
		send_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_request(REQ_FIT, 0, 0, 0);
		// Random phases, each under a different window size.
		for (int phase = 0; phase < 6; phase++) begin
			write_window(sizes[phase]);
			style = $urandom_range(0, 3);
			for (int k = 0; k < 155; k++) begin
				pick = $urandom_range(0, 99);
				xv = random_coord(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : style);
				yv = random_coord(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : style);
				if (pick < 55) send_request(REQ_ADD, xv, yv, phase != 3);
				else if (pick < 75) send_request(REQ_FIT, xv, yv, phase != 3);
				else if (pick < 97) send_request(REQ_PREDICT, xv, yv, phase != 3);
				else send_request(REQ_CLEAR, xv, yv, phase != 3);
			end
		end
		wait (pending_count == 0);
		repeat (700) @(posedge clk);
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
design/swlr_pkg.sv
design/swlr_ifs.sv
design/swlr_mul.sv
design/swlr_div.sv
design/swlr_dp.sv
design/swlr_ctrl.sv
design/sliding_window_linear_regression.sv
tb/sv/swlr_tb_pkg.sv
tb/sv/swlr_tb_ifs.sv
tb/sv/swlr_checker.sv
tb/sv/tb_sliding_window_linear_regression.sv
